// File: hdl/fbr_pkg.sv
// Shared types and constants for the framed byte receiver with acknowledge.
// Used by every module in hdl; depends on nothing.
`default_nettype none
package fbr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 49;
   localparam int QUEUE_DEPTH = 2;
   localparam int ACK_BYTES = 7;

   localparam logic [7:0] HDR1 = 8'hAA;
   localparam logic [7:0] HDR2 = 8'hAF;
   localparam logic [7:0] FUNC_LIMIT = 8'hF1;
   localparam logic [7:0] ACK_HDR = 8'hAA;
   localparam logic [7:0] ACK_ID = 8'hEF;
   localparam logic [7:0] ACK_LEN = 8'h02;
   localparam logic [7:0] ACK_FUNC_RESET = 8'h10;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_HDR2    = 3'd2,
      PH_FUNC    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CKS     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      AB_HDR_A = 3'd0,
      AB_HDR_B = 3'd1,
      AB_ID    = 3'd2,
      AB_LEN   = 3'd3,
      AB_FUNC  = 3'd4,
      AB_SUM   = 3'd5,
      AB_CKS   = 3'd6
   } ack_beat_type;

   typedef struct packed {
      logic [7:0] func;
      logic [7:0] sum;
   } ack_entry_type;

   typedef struct packed {
      logic          valid;
      ack_entry_type entry;
   } ack_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// File: hdl/fbr_parser.sv
// Front end: frame parser that checks header, length and checksum of received bytes.
// Depends on fbr_pkg; pushes one acknowledge request per good matching frame.
`default_nettype none
module fbr_parser #(
   parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_accept,
   input  wire logic [7:0]           rx_byte,
   input  wire logic [7:0]           ack_code,
   output fbr_pkg::ack_push_type     push
);
   localparam int LenW = $clog2(MAX_PAYLOAD + 1);

   fbr_pkg::phase_type phase_ff, phase_in;
   logic [LenW-1:0]    remain_ff, remain_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         func_ff, func_in;
   logic               len_ok;
   logic [LenW-1:0]    remain_dec;

   assign len_ok = ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD));
   assign remain_dec = remain_ff - LenW'(1);

   always_comb begin
      phase_in = phase_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            fbr_pkg::PH_IDLE:
               phase_in = (rx_byte == fbr_pkg::HDR1) ? fbr_pkg::PH_HDR1 : fbr_pkg::PH_IDLE;
            fbr_pkg::PH_HDR1:
               phase_in = (rx_byte == fbr_pkg::HDR2) ? fbr_pkg::PH_HDR2 : fbr_pkg::PH_IDLE;
            fbr_pkg::PH_HDR2:
               phase_in = (rx_byte < fbr_pkg::FUNC_LIMIT) ? fbr_pkg::PH_FUNC : fbr_pkg::PH_IDLE;
            fbr_pkg::PH_FUNC:
               phase_in = len_ok ? fbr_pkg::PH_PAYLOAD : fbr_pkg::PH_IDLE;
            fbr_pkg::PH_PAYLOAD: begin
               if (remain_ff == '0) begin
                  phase_in = fbr_pkg::PH_IDLE;
               end else if (remain_dec == '0) begin
                  phase_in = fbr_pkg::PH_CKS;
               end
            end
            default:
               phase_in = fbr_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      remain_in = remain_ff;
      sum_in = sum_ff;
      func_in = func_ff;
      push.valid = 1'b0;
      push.entry.func = func_ff;
      push.entry.sum = sum_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            fbr_pkg::PH_IDLE: begin
               sum_in = rx_byte;
            end
            fbr_pkg::PH_HDR1, fbr_pkg::PH_HDR2: begin
               sum_in = sum_ff + rx_byte;
               if (phase_ff == fbr_pkg::PH_HDR2) begin
                  func_in = rx_byte;
               end
            end
            fbr_pkg::PH_FUNC: begin
               sum_in = sum_ff + rx_byte;
               remain_in = LenW'(rx_byte);
            end
            fbr_pkg::PH_PAYLOAD: begin
               if (remain_ff != '0) begin
                  sum_in = sum_ff + rx_byte;
                  remain_in = remain_dec;
               end
            end
            fbr_pkg::PH_CKS: begin
               push.valid = (rx_byte == sum_ff) && (func_ff == ack_code);
            end
            default: begin
               sum_in = sum_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fbr_pkg::PH_IDLE;
         remain_ff <= '0;
         sum_ff <= '0;
         func_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         remain_ff <= remain_in;
         sum_ff <= sum_in;
         func_ff <= func_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/fbr_ack_queue.sv
// Short queue of pending acknowledge requests between parser and sender.
// Depends on fbr_pkg for the entry and status types.
`default_nettype none
module fbr_ack_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fbr_pkg::ack_push_type push,
   input  wire logic                  pop,
   output fbr_pkg::ack_entry_type     head,
   output fbr_pkg::queue_status_type  status
);
   localparam int Depth = fbr_pkg::QUEUE_DEPTH;
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   fbr_pkg::ack_entry_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign do_push = push.valid && !status.full;
   assign do_pop = pop && !status.empty;
   assign status.full = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/fbr_ack_gen.sv
// Back end: turns one queued request into the seven-beat acknowledge frame.
// Depends on fbr_pkg; drives the registered response channel.
`default_nettype none
module fbr_ack_gen (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire fbr_pkg::ack_entry_type  q_head,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_tx_byte,
   output logic                         rsp_tx_last
);
   logic                   active_ff, active_in;
   fbr_pkg::ack_beat_type  beat_ff, beat_in;
   fbr_pkg::ack_entry_type entry_ff, entry_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic                   advance;
   logic [7:0]             beat_byte;
   logic [7:0]             ack_cks;

   assign advance = !valid_ff || rsp_ready;
   assign q_pop = !active_ff && q_valid;
   assign ack_cks = fbr_pkg::ACK_HDR + fbr_pkg::ACK_HDR + fbr_pkg::ACK_ID
                  + fbr_pkg::ACK_LEN + entry_ff.func + entry_ff.sum;

   always_comb begin
      unique case (beat_ff)
         fbr_pkg::AB_HDR_A, fbr_pkg::AB_HDR_B: beat_byte = fbr_pkg::ACK_HDR;
         fbr_pkg::AB_ID:   beat_byte = fbr_pkg::ACK_ID;
         fbr_pkg::AB_LEN:  beat_byte = fbr_pkg::ACK_LEN;
         fbr_pkg::AB_FUNC: beat_byte = entry_ff.func;
         fbr_pkg::AB_SUM:  beat_byte = entry_ff.sum;
         default:          beat_byte = ack_cks;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      beat_in = beat_ff;
      entry_in = entry_ff;
      valid_in = valid_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      if (q_pop) begin
         active_in = 1'b1;
         beat_in = fbr_pkg::AB_HDR_A;
         entry_in = q_head;
      end
      if (advance) begin
         valid_in = active_ff;
         if (active_ff) begin
            byte_in = beat_byte;
            last_in = (beat_ff == fbr_pkg::AB_CKS);
            if (beat_ff == fbr_pkg::AB_CKS) begin
               active_in = 1'b0;
            end else begin
               beat_in = fbr_pkg::ack_beat_type'(beat_ff + 3'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         beat_ff <= fbr_pkg::AB_HDR_A;
         valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         beat_ff <= beat_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_tx_last = last_ff;

endmodule
`default_nettype wire

// File: hdl/framed_byte_receiver_with_ack.sv
// Top level of the framed byte receiver: parser, request queue and acknowledge sender.
// Depends on fbr_pkg, fbr_parser, fbr_ack_queue and fbr_ack_gen.
//
// The block takes one received byte per clock cycle and parses frames of the form
// AA AF func len payload cks; a good frame whose function byte equals the configured
// code produces the seven-beat acknowledge AA AA EF 02 func sum cks, with rsp_tx_last
// on the final beat. Input is held off only while the two-entry queue of pending
// acknowledges is full; the sender first loads a queued request and then delivers its
// seven beats at one per cycle while rsp_ready allows, through an output register.
`default_nettype none
module framed_byte_receiver_with_ack #(
   parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_tx_last,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);
   logic [7:0]                 ack_code_ff, ack_code_in;
   fbr_pkg::ack_push_type      push;
   fbr_pkg::ack_entry_type     q_head;
   fbr_pkg::queue_status_type  q_status;
   logic                       q_pop;
   logic                       byte_accept;

   assign req_ready = !q_status.full;
   assign byte_accept = req_valid && req_ready;
   assign ack_code_in = csr_we ? csr_wdata : ack_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff <= fbr_pkg::ACK_FUNC_RESET;
      end else begin
         ack_code_ff <= ack_code_in;
      end
   end

   fbr_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .rx_byte    (req_rx_byte),
      .ack_code   (ack_code_ff),
      .push       (push)
   );

   fbr_ack_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .head  (q_head),
      .status(q_status)
   );

   fbr_ack_gen u_ack_gen (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_status.empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last)
   );

`ifndef SYNTHESIS
   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (req_valid && req_ready))
      else $error("acknowledge request raised without an accepted byte");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_status.full)
      else $error("acknowledge request pushed into a full queue");

   a_queue_status_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   a_ack_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_tx_last) |=> rsp_valid)
      else $error("gap inside an acknowledge frame");
`endif

endmodule
`default_nettype wire
